[hw/rtl/wsfrx_pkg.sv]
// Shared types, widths and codes for the WebSocket inbound frame parser.
// No dependencies; every other file of the block uses it.
package wsfrx_pkg;

	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 64;
	localparam int OP_W       = 4;
	localparam int RSV_W      = 3;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;
	localparam int OUT_DEPTH  = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MASK_ENFORCE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RSV_PERMIT   = 8'd1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_EXT      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_OP_CHANGED   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN_OP   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_MASK_MISSING = 3'd4;

	// opcodes
	localparam logic [OP_W-1:0] OP_CONT   = 4'h0;
	localparam logic [OP_W-1:0] OP_TEXT   = 4'h1;
	localparam logic [OP_W-1:0] OP_BINARY = 4'h2;
	localparam logic [OP_W-1:0] OP_CLOSE  = 4'h8;
	localparam logic [OP_W-1:0] OP_PING   = 4'h9;
	localparam logic [OP_W-1:0] OP_PONG   = 4'ha;

	// 7-bit length escapes
	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	typedef struct packed {
		logic                  payload_valid;
		logic [BYTE_W-1:0]     payload_byte;
		logic                  message_start;
		logic                  fragment_start;
		logic [LEN_W-1:0]      fragment_length;
		logic                  fragment_end;
		logic                  message_end;
		logic [OP_W-1:0]       message_opcode;
		logic                  final_fragment;
		logic                  frame_masked;
		logic [RSV_W-1:0]      extension_bits;
		logic [STATUS_W-1:0]   status;
	} result_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	function automatic logic known_opcode(input logic [OP_W-1:0] op);
		return op == OP_TEXT || op == OP_BINARY || op == OP_CLOSE ||
			op == OP_PING || op == OP_PONG;
	endfunction

endpackage

[hw/rtl/wsfrx_byte_if.sv]
// Inbound byte channel: valid/ready handshake plus one stream byte.
// Depends on wsfrx_pkg for widths.
interface wsfrx_byte_if;
	logic                        valid;
	logic                        ready;
	logic [wsfrx_pkg::BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

[hw/rtl/wsfrx_res_if.sv]
// Result channel: valid/ready handshake plus the per-byte parse result fields.
// Depends on wsfrx_pkg for widths.
interface wsfrx_res_if;
	logic                           valid;
	logic                           ready;
	logic                           payload_valid;
	logic [wsfrx_pkg::BYTE_W-1:0]   payload_byte;
	logic                           message_start;
	logic                           fragment_start;
	logic [wsfrx_pkg::LEN_W-1:0]    fragment_length;
	logic                           fragment_end;
	logic                           message_end;
	logic [wsfrx_pkg::OP_W-1:0]     message_opcode;
	logic                           final_fragment;
	logic                           frame_masked;
	logic [wsfrx_pkg::RSV_W-1:0]    extension_bits;
	logic [wsfrx_pkg::STATUS_W-1:0] status;

	modport source (output valid, input ready, output payload_valid, output payload_byte,
		output message_start, output fragment_start, output fragment_length,
		output fragment_end, output message_end, output message_opcode,
		output final_fragment, output frame_masked, output extension_bits, output status);
	modport sink (input valid, output ready, input payload_valid, input payload_byte,
		input message_start, input fragment_start, input fragment_length,
		input fragment_end, input message_end, input message_opcode,
		input final_fragment, input frame_masked, input extension_bits, input status);
endinterface

[hw/rtl/wsfrx_cfg_if.sv]
// Configuration write channel: valid/ready plus register index and write data.
// Depends on wsfrx_pkg for widths.
interface wsfrx_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [wsfrx_pkg::CFG_IDX_W-1:0]  index;
	logic [wsfrx_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/wsfrx_core.sv]
// Frame parse state and single-cycle per-byte update, plus config registers.
// Depends on wsfrx_pkg.
module wsfrx_core
	import wsfrx_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_wr_t           cfg_wr,
	input  logic              en,
	input  logic [BYTE_W-1:0] byte_s1,
	output result_t           res
);

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_LEN1   = 3'd1;
	localparam logic [2:0] PH_LEN16  = 3'd2;
	localparam logic [2:0] PH_LEN64  = 3'd3;
	localparam logic [2:0] PH_MASK   = 3'd4;
	localparam logic [2:0] PH_DATA   = 3'd5;

	logic                mask_enforce_q;
	logic [RSV_W-1:0]    rsv_permit_q;

	logic [2:0]          phase_q, phase_d;
	logic [OP_W-1:0]     cur_op_q, cur_op_d, cur_op_next;
	logic                fin_q, fin_d;
	logic [RSV_W-1:0]    rsv_q, rsv_d;
	logic                mask_q, mask_d;
	logic [2:0]          hbc_q, hbc_d, hbc_inc;
	logic [LEN_W-1:0]    acc_q, acc_d, acc_shift;
	logic [LEN_W-1:0]    rem_q, rem_d, rem_dec;
	logic [31:0]         key_q, key_d;
	logic [1:0]          midx_q, midx_d;
	logic [STATUS_W-1:0] err_q, err_d;

	logic                len_done;
	logic [LEN_W-1:0]    len_val;
	logic [BYTE_W-1:0]   key_byte;
	logic [OP_W-1:0]     op;
	logic                pv, mstart, fstart, fend, mend;
	logic [BYTE_W-1:0]   pbyte;
	logic [LEN_W-1:0]    flen;

	assign hbc_inc   = hbc_q + 3'd1;
	assign acc_shift = {acc_q[LEN_W-BYTE_W-1:0], byte_s1};
	assign rem_dec   = rem_q - LEN_W'(1);
	assign op        = byte_s1[OP_W-1:0];

	always_comb begin
		unique case (midx_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		cur_op_d = cur_op_q;
		fin_d    = fin_q;
		rsv_d    = rsv_q;
		mask_d   = mask_q;
		hbc_d    = hbc_q;
		acc_d    = acc_q;
		rem_d    = rem_q;
		key_d    = key_q;
		midx_d   = midx_q;
		err_d    = err_q;
		len_done = 1'b0;
		len_val  = '0;
		pv       = 1'b0;
		pbyte    = '0;
		mstart   = 1'b0;
		fstart   = 1'b0;
		flen     = '0;
		fend     = 1'b0;
		if (err_q == ST_OK) begin
			unique case (phase_q)
				PH_LEN1: begin
					mask_d = byte_s1[7];
					if (mask_enforce_q && !byte_s1[7]) begin
						err_d = ST_MASK_MISSING;
					end else begin
						acc_d = '0;
						hbc_d = '0;
						if (byte_s1[6:0] == LEN7_EXT16) begin
							phase_d = PH_LEN16;
						end else if (byte_s1[6:0] == LEN7_EXT64) begin
							phase_d = PH_LEN64;
						end else begin
							len_done = 1'b1;
							len_val  = LEN_W'(byte_s1[6:0]);
						end
					end
				end
				PH_LEN16, PH_LEN64: begin
					acc_d = acc_shift;
					hbc_d = hbc_inc;
					// 64-bit length: the 3-bit count wraps to zero on byte eight
					if ((phase_q == PH_LEN16 && hbc_inc == 3'd2) ||
						(phase_q == PH_LEN64 && hbc_inc == 3'd0)) begin
						len_done = 1'b1;
						len_val  = acc_shift;
					end
				end
				PH_MASK: begin
					key_d = {key_q[23:0], byte_s1};
					hbc_d = hbc_inc;
					if (hbc_inc >= 3'd4) begin
						hbc_d  = '0;
						midx_d = '0;
						if (rem_q == '0) begin
							fend    = 1'b1;
							phase_d = PH_HEADER;
						end else begin
							phase_d = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					pv     = 1'b1;
					pbyte  = mask_q ? (byte_s1 ^ key_byte) : byte_s1;
					midx_d = midx_q + 2'd1;
					rem_d  = rem_dec;
					if (rem_dec == '0) begin
						fend    = 1'b1;
						phase_d = PH_HEADER;
					end
				end
				default: begin
					// header byte; unused phase codes land here too
					fin_d = byte_s1[7];
					rsv_d = byte_s1[6:4];
					if ((byte_s1[6:4] & ~rsv_permit_q) != '0) begin
						err_d = ST_BAD_EXT;
					end else if (cur_op_q != OP_CONT && op != OP_CONT) begin
						err_d = ST_OP_CHANGED;
					end else if (cur_op_q == OP_CONT) begin
						if (!known_opcode(op)) begin
							err_d = ST_UNKNOWN_OP;
						end else begin
							cur_op_d = op;
							mstart   = 1'b1;
							phase_d  = PH_LEN1;
						end
					end else begin
						phase_d = PH_LEN1;
					end
				end
			endcase
			if (len_done) begin
				fstart = 1'b1;
				flen   = len_val;
				rem_d  = len_val;
				hbc_d  = '0;
				midx_d = '0;
				if (mask_d) begin
					phase_d = PH_MASK;
				end else if (len_val == '0) begin
					fend    = 1'b1;
					phase_d = PH_HEADER;
				end else begin
					phase_d = PH_DATA;
				end
			end
		end
		mend        = fend && fin_d;
		cur_op_next = mend ? OP_CONT : cur_op_d;
	end

	always_comb begin
		res.payload_valid   = pv;
		res.payload_byte    = pbyte;
		res.message_start   = mstart;
		res.fragment_start  = fstart;
		res.fragment_length = flen;
		res.fragment_end    = fend;
		res.message_end     = mend;
		res.message_opcode  = cur_op_d;
		res.final_fragment  = fin_d;
		res.frame_masked    = mask_d;
		res.extension_bits  = rsv_d;
		res.status          = err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_enforce_q <= 1'b0;
			rsv_permit_q   <= '0;
		end else if (cfg_wr.we) begin
			if (cfg_wr.index == REG_MASK_ENFORCE) begin
				mask_enforce_q <= cfg_wr.data[0];
			end else if (cfg_wr.index == REG_RSV_PERMIT) begin
				rsv_permit_q <= cfg_wr.data[RSV_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			cur_op_q <= OP_CONT;
			fin_q    <= 1'b0;
			rsv_q    <= '0;
			mask_q   <= 1'b0;
			hbc_q    <= '0;
			acc_q    <= '0;
			rem_q    <= '0;
			key_q    <= '0;
			midx_q   <= '0;
			err_q    <= ST_OK;
		end else if (en) begin
			phase_q  <= phase_d;
			cur_op_q <= cur_op_next;
			fin_q    <= fin_d;
			rsv_q    <= rsv_d;
			mask_q   <= mask_d;
			hbc_q    <= hbc_d;
			acc_q    <= acc_d;
			rem_q    <= rem_d;
			key_q    <= key_d;
			midx_q   <= midx_d;
			err_q    <= err_d;
		end
	end

`ifndef SYNTHESIS
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != ST_OK |=> err_q == $past(err_q))
		else $error("error code changed after being set");
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		en && err_q != ST_OK |-> !res.payload_valid && !res.message_start &&
		!res.fragment_start && !res.fragment_end && !res.message_end)
		else $error("events raised while in error");
	a_end_to_header: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.fragment_end |=> phase_q == PH_HEADER)
		else $error("fragment ended without returning to header");
`endif

endmodule

[hw/rtl/wsfrx_out_fifo.sv]
// Small result queue decoupling the parser from the result channel's ready.
// Depends on wsfrx_pkg for the result type.
module wsfrx_out_fifo
	import wsfrx_pkg::*;
#(
	parameter int DEPTH = OUT_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  result_t                    push_data,
	input  logic                       pop_ready,
	output logic                       out_valid,
	output result_t                    out_data,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	result_t         mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            pop;

	assign out_valid = count_q != '0;
	assign pop       = out_valid && pop_ready;
	assign out_data  = mem_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("result queue overflow");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count did not rise on push");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - CW'(1))
		else $error("queue count did not fall on pop");
`endif

endmodule

[hw/rtl/websocket_frame_rx_parser.sv]
// Top level of the WebSocket inbound frame parser: input register, parse core
// and result queue. Depends on wsfrx_pkg, the three channel interfaces,
// wsfrx_core and wsfrx_out_fifo.
//
// One stream byte per item on rx, one result item on res for every byte, in
// order. Sustained rate is one byte per clock while res keeps taking results:
// the whole header/length/mask/payload state update is a single-cycle step in
// the core, so bytes flow back to back. A result becomes valid on res once its
// byte has passed the input register and the core result has been written
// into the queue. The result queue holds OUT_DEPTH_P items; rx.ready drops
// only while the queue plus the byte in the input register already hold that
// many, so res stalls back-pressure rx without losing items. Config writes
// (index 0 mask enforcement, index 1 permitted RSV bits) are always accepted
// and should be issued only while idle. Any protocol error is sticky until
// reset: status holds its code and all event flags and payload_valid read
// zero from then on.
module websocket_frame_rx_parser
	import wsfrx_pkg::*;
#(
	parameter int OUT_DEPTH_P = OUT_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	wsfrx_cfg_if.sink     cfg,
	wsfrx_byte_if.sink    rx,
	wsfrx_res_if.source   res
);

	localparam int CW = $clog2(OUT_DEPTH_P + 1);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              accept;
	cfg_wr_t           cfg_wr;
	result_t           core_res;
	result_t           q_res;
	logic [CW-1:0]     q_count;

	// room check counts the byte already held in the input register
	assign rx.ready = ({1'b0, q_count} + (CW + 1)'(valid_s1)) < (CW + 1)'(OUT_DEPTH_P);
	assign accept   = rx.valid && rx.ready;

	assign cfg.ready    = 1'b1;
	assign cfg_wr.we    = cfg.valid;
	assign cfg_wr.index = cfg.index;
	assign cfg_wr.data  = cfg.data;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx.in_byte;
		end
	end

	wsfrx_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_wr  (cfg_wr),
		.en      (valid_s1),
		.byte_s1 (byte_s1),
		.res     (core_res)
	);

	wsfrx_out_fifo #(
		.DEPTH (OUT_DEPTH_P)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (core_res),
		.pop_ready (res.ready),
		.out_valid (res.valid),
		.out_data  (q_res),
		.count     (q_count)
	);

	assign res.payload_valid   = q_res.payload_valid;
	assign res.payload_byte    = q_res.payload_byte;
	assign res.message_start   = q_res.message_start;
	assign res.fragment_start  = q_res.fragment_start;
	assign res.fragment_length = q_res.fragment_length;
	assign res.fragment_end    = q_res.fragment_end;
	assign res.message_end     = q_res.message_end;
	assign res.message_opcode  = q_res.message_opcode;
	assign res.final_fragment  = q_res.final_fragment;
	assign res.frame_masked    = q_res.frame_masked;
	assign res.extension_bits  = q_res.extension_bits;
	assign res.status          = q_res.status;

`ifndef SYNTHESIS
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, q_count} + (CW + 1)'(valid_s1)) <= (CW + 1)'(OUT_DEPTH_P))
		else $error("queue credit exceeded");
	a_s1_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted byte not registered");
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !valid_s1)
		else $error("input register valid without acceptance");
`endif

endmodule

[test/tb_websocket_frame_rx_parser.sv]
`timescale 1ns / 100ps
// Self-checking bench for websocket_frame_rx_parser: directed and random frames go in
// byte by byte, and every result is checked against an in-bench parse model or a typed-in value.
// Depends on wsfrx_pkg, the byte/result/config interfaces and the RTL top level.
module tb_websocket_frame_rx_parser;
	import wsfrx_pkg::*;

	// parse position inside a frame
	typedef enum logic [2:0] {
		RXP_HEADER, RXP_LEN7, RXP_LEN16, RXP_LEN64, RXP_KEY, RXP_DATA
	} rx_phase_e;

	// how the payload length is encoded on the wire
	typedef enum int {LF_SHORT, LF_EXT16, LF_EXT64} len_form_e;

	// errors are sticky until reset, so each run ends on exactly one of these
	typedef enum int {
		END_HUGE_LEN, END_BAD_EXT, END_OP_CHANGED, END_UNKNOWN_OP, END_MASK_MISSING
	} closing_case_e;

	localparam int DIR_ROWS    = 27;
	localparam int PHASE_BYTES = 70;
	localparam int NOISE_BYTES = 30;
	localparam int MAX_SHOWN   = 10;

	logic clk;
	logic arst_n;

	wsfrx_cfg_if  cfg_ch ();
	wsfrx_byte_if rx_ch ();
	wsfrx_res_if  res_ch ();

	websocket_frame_rx_parser DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	// ---------------------------------------------------------------------
	// Parse model state and its copy of the two registers
	// ---------------------------------------------------------------------
	logic                need_mask;
	logic [RSV_W-1:0]    rsv_allow;
	rx_phase_e           ph;
	logic [OP_W-1:0]     open_op;     // OP_CONT while no message is open
	logic                hdr_fin;
	logic                hdr_masked;
	logic [RSV_W-1:0]    hdr_rsv;
	logic [2:0]          hdr_cnt;     // length / key byte counter, wraps at 8
	logic [LEN_W-1:0]    len_acc;
	logic [LEN_W-1:0]    left;        // payload bytes still due in this fragment
	logic [31:0]         key;
	logic [1:0]          key_pos;
	logic [STATUS_W-1:0] err;

	result_t pending_results[$];

	bit quiet;          // no idling on either side
	int bytes_sent;
	int msgs_sent;
	int results_checked;
	int bad_results;

	// Directed stream, walked in order right after reset with RSV all allowed.
	logic [BYTE_W-1:0] dir_bytes [DIR_ROWS] = '{
		// text with FIN, empty and unmasked: starts and ends on its length byte
		8'h81, 8'h00,
		// binary with every RSV bit, empty and masked: ends on the last key byte
		8'hF2, 8'h80, 8'hFF, 8'h00, 8'hA5, 8'h5A,
		// first text fragment, masked, two payload bytes with top-bit extremes
		8'h01, 8'h82, 8'h12, 8'h34, 8'h56, 8'h78, 8'hFF, 8'h80,
		// FIN continuation, 16-bit length of one
		8'h80, 8'h7E, 8'h00, 8'h01, 8'h55,
		// close, ping and pong, all empty
		8'h88, 8'h00, 8'h89, 8'h00, 8'h8A, 8'h00
	};

	// Rows whose result is typed in rather than predicted.
	function automatic logic pinned_row(input int row, output result_t want);
		want = '0;
		case (row)
			0: want = '{message_start: 1'b1, message_opcode: OP_TEXT, final_fragment: 1'b1,
				default: 0};
			1: want = '{fragment_start: 1'b1, fragment_end: 1'b1, message_end: 1'b1,
				message_opcode: OP_TEXT, final_fragment: 1'b1, default: 0};
			2: want = '{message_start: 1'b1, message_opcode: OP_BINARY, final_fragment: 1'b1,
				extension_bits: 3'b111, default: 0};
			3: want = '{fragment_start: 1'b1, message_opcode: OP_BINARY, final_fragment: 1'b1,
				frame_masked: 1'b1, extension_bits: 3'b111, default: 0};
			7: want = '{fragment_end: 1'b1, message_end: 1'b1, message_opcode: OP_BINARY,
				final_fragment: 1'b1, frame_masked: 1'b1, extension_bits: 3'b111, default: 0};
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic logic is_msg_opcode(input logic [OP_W-1:0] op);
		case (op)
			OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Length is known: go to key or payload. True when the frame is empty and
	// unmasked, so it closes on this very byte.
	function automatic logic load_length(input logic [LEN_W-1:0] n);
		left = n;
		hdr_cnt = '0;
		key_pos = '0;
		if (hdr_masked) begin
			ph = RXP_KEY;
			return 1'b0;
		end
		if (n == '0)
			return 1'b1;
		ph = RXP_DATA;
		return 1'b0;
	endfunction

	// One stream byte in, the result item it produces out.
	function automatic result_t parse_byte(input logic [BYTE_W-1:0] b);
		result_t r;
		logic done;
		logic [BYTE_W-1:0] k;
		logic [OP_W-1:0] op;
		r = '0;
		done = 1'b0;
		k = '0;
		op = b[3:0];
		if (err == ST_OK) begin
			case (ph)
				RXP_LEN7: begin
					hdr_masked = b[7];
					if (need_mask && !b[7]) begin
						err = ST_MASK_MISSING;
					end else begin
						len_acc = '0;
						hdr_cnt = '0;
						if (b[6:0] == LEN7_EXT16) begin
							ph = RXP_LEN16;
						end else if (b[6:0] == LEN7_EXT64) begin
							ph = RXP_LEN64;
						end else begin
							r.fragment_start = 1'b1;
							r.fragment_length = LEN_W'(b[6:0]);
							done = load_length(LEN_W'(b[6:0]));
						end
					end
				end
				RXP_LEN16, RXP_LEN64: begin
					len_acc = {len_acc[LEN_W-9:0], b};
					hdr_cnt = hdr_cnt + 3'd1;
					// eight bytes wrap the counter back to zero
					if (hdr_cnt == (ph == RXP_LEN16 ? 3'd2 : 3'd0)) begin
						r.fragment_start = 1'b1;
						r.fragment_length = len_acc;
						done = load_length(len_acc);
					end
				end
				RXP_KEY: begin
					key = {key[23:0], b};
					hdr_cnt = hdr_cnt + 3'd1;
					if (hdr_cnt >= 3'd4) begin
						hdr_cnt = '0;
						key_pos = '0;
						if (left == '0)
							done = 1'b1;
						else
							ph = RXP_DATA;
					end
				end
				RXP_DATA: begin
					if (hdr_masked)
						k = key[8 * (3 - key_pos) +: 8];
					r.payload_valid = 1'b1;
					r.payload_byte = b ^ k;
					key_pos = key_pos + 2'd1;
					left = left - 1'b1;
					if (left == '0)
						done = 1'b1;
				end
				default: begin
					hdr_fin = b[7];
					hdr_rsv = b[6:4];
					if ((hdr_rsv & ~rsv_allow) != '0) begin
						err = ST_BAD_EXT;
					end else if (open_op != OP_CONT && op != OP_CONT) begin
						err = ST_OP_CHANGED;
					end else if (open_op == OP_CONT) begin
						if (!is_msg_opcode(op)) begin
							err = ST_UNKNOWN_OP;
						end else begin
							open_op = op;
							r.message_start = 1'b1;
							ph = RXP_LEN7;
						end
					end else begin
						ph = RXP_LEN7;
					end
				end
			endcase
		end
		if (done) begin
			r.fragment_end = 1'b1;
			r.message_end = hdr_fin;
			ph = RXP_HEADER;
		end
		// the ending message still reports its own opcode
		r.message_opcode = open_op;
		if (r.message_end)
			open_op = OP_CONT;
		r.final_fragment = hdr_fin;
		r.frame_masked = hdr_masked;
		r.extension_bits = hdr_rsv;
		r.status = err;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------

	// Offers one byte; valid stays high afterwards so back-to-back items flow.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic pinned = 1'b0,
			input result_t want = '0);
		result_t predicted;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.in_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		predicted = parse_byte(b);
		pending_results.push_back(pinned ? want : predicted);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic fin, input logic [OP_W-1:0] op, input logic masked,
			input logic [LEN_W-1:0] n, input len_form_e form);
		logic [31:0] mkey;
		logic [RSV_W-1:0] rsv;
		mkey = $urandom;
		rsv = RSV_W'($urandom) & rsv_allow;
		send_byte({fin, rsv, op});
		case (form)
			LF_SHORT: send_byte({masked, n[6:0]});
			LF_EXT16: begin
				send_byte({masked, LEN7_EXT16});
				send_byte(n[15:8]);
				send_byte(n[7:0]);
			end
			default: begin
				send_byte({masked, LEN7_EXT64});
				for (int i = 7; i >= 0; i--)
					send_byte(n[8*i +: 8]);
			end
		endcase
		if (masked)
			for (int i = 3; i >= 0; i--)
				send_byte(mkey[8*i +: 8]);
		for (longint unsigned j = 0; j < n; j++)
			send_byte(BYTE_W'($urandom));
	endtask

	// A well-formed message: data may be split into up to three fragments,
	// control frames always come whole. Lengths stay small, with a few
	// extended encodings and the largest 7-bit length (125) now and then.
	task automatic send_message();
		logic [OP_W-1:0] msg_ops [5];
		logic [OP_W-1:0] op;
		logic [LEN_W-1:0] n;
		len_form_e form;
		int frags;
		int pick;
		msg_ops = '{OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG};
		op = msg_ops[$urandom_range(0, 4)];
		frags = (op == OP_TEXT || op == OP_BINARY) ? $urandom_range(1, 3) : 1;
		for (int f = 0; f < frags; f++) begin
			pick = $urandom_range(0, 19);
			if (pick < 13) begin
				form = LF_SHORT;
				n = (pick == 0) ? LEN_W'(125) : LEN_W'($urandom_range(0, 12));
			end else if (pick < 17) begin
				form = LF_EXT16;
				n = LEN_W'($urandom_range(0, 48));
			end else begin
				form = LF_EXT64;
				n = LEN_W'($urandom_range(0, 24));
			end
			send_frame(f == frags - 1, f == 0 ? op : OP_CONT,
				need_mask | 1'($urandom), n, form);
		end
		msgs_sent++;
	endtask

	// Both registers, one write each; the model follows at each handshake.
	task automatic set_config(input logic need, input logic [RSV_W-1:0] allow);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= REG_MASK_ENFORCE;
		cfg_ch.data <= CFG_DATA_W'(need);
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		need_mask = need;
		cfg_ch.index <= REG_RSV_PERMIT;
		cfg_ch.data <= CFG_DATA_W'(allow);
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		rsv_allow = allow;
		cfg_ch.valid <= 1'b0;
	endtask

	// Sender holds off until every predicted result has been seen.
	task automatic wait_drained();
		rx_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Clock, result sink, checker, watchdog
	// ---------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Ready drops in random bursts, except in quiet stretches.
	initial begin
		int stall;
		res_ch.ready = 1'b0;
		stall = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall > 0)
				stall--;
			else if (!quiet && $urandom_range(0, 5) == 0)
				stall = $urandom_range(1, 6);
			res_ch.ready <= (stall == 0);
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = {res_ch.payload_valid, res_ch.payload_byte, res_ch.message_start,
				res_ch.fragment_start, res_ch.fragment_length, res_ch.fragment_end,
				res_ch.message_end, res_ch.message_opcode, res_ch.final_fragment,
				res_ch.frame_masked, res_ch.extension_bits, res_ch.status};
			if (pending_results.size() == 0) begin
				bad_results++;
				if (bad_results <= MAX_SHOWN)
					$display("tb: result with nothing pending at %0t", $realtime);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (got !== want) begin
					bad_results++;
					if (bad_results <= MAX_SHOWN) begin
						$display("tb: result %0d mismatch at %0t", results_checked, $realtime);
						$display("  exp pv=%b pb=%h ms=%b fs=%b fl=%h fe=%b me=%b",
							want.payload_valid, want.payload_byte, want.message_start,
							want.fragment_start, want.fragment_length,
							want.fragment_end, want.message_end);
						$display("      op=%h fin=%b mk=%b rsv=%b st=%0d",
							want.message_opcode, want.final_fragment, want.frame_masked,
							want.extension_bits, want.status);
						$display("  got pv=%b pb=%h ms=%b fs=%b fl=%h fe=%b me=%b",
							got.payload_valid, got.payload_byte, got.message_start,
							got.fragment_start, got.fragment_length,
							got.fragment_end, got.message_end);
						$display("      op=%h fin=%b mk=%b rsv=%b st=%0d",
							got.message_opcode, got.final_fragment, got.frame_masked,
							got.extension_bits, got.status);
					end
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Run sequence
	// ---------------------------------------------------------------------
	initial begin
		closing_case_e closing;
		result_t want;
		logic pinned;
		logic [OP_W-1:0] op;
		int dir_count;
		int start;

		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.in_byte = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		quiet = 1'b0;
		bytes_sent = 0;
		msgs_sent = 0;
		results_checked = 0;
		bad_results = 0;

		// model reset state
		need_mask = 1'b0;
		rsv_allow = '0;
		ph = RXP_HEADER;
		open_op = OP_CONT;
		hdr_fin = 1'b0;
		hdr_masked = 1'b0;
		hdr_rsv = '0;
		hdr_cnt = '0;
		len_acc = '0;
		left = '0;
		key = '0;
		key_pos = '0;
		err = ST_OK;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed stream: every opcode, both empty-frame endings, RSV extremes
		set_config(1'b0, 3'd7);
		for (int i = 0; i < DIR_ROWS; i++) begin
			pinned = pinned_row(i, want);
			send_byte(dir_bytes[i], pinned, want);
		end
		dir_count = bytes_sent;

		// random messages under four register settings, extremes first;
		// the last setting runs with no idling at all
		for (int p = 0; p < 4; p++) begin
			wait_drained();
			case (p)
				0: set_config(1'b0, 3'd0);
				1: set_config(1'b1, 3'd7);
				2: set_config(1'b1, RSV_W'($urandom_range(0, 6)));
				default: begin
					quiet = 1'b1;
					set_config(1'b0, RSV_W'($urandom_range(0, 7)));
				end
			endcase
			start = bytes_sent;
			while (bytes_sent - start < PHASE_BYTES)
				send_message();
		end
		wait_drained();

		// Closing stage: a frame that never ends, or one error that locks the
		// parser; the noise after it must be ignored (or passed as payload).
		closing = closing_case_e'($urandom_range(0, 4));
		case (closing)
			END_HUGE_LEN: begin
				send_byte({1'b1, 3'b000, OP_BINARY});
				send_byte({1'b0, LEN7_EXT64});
				send_byte(8'h80 | BYTE_W'($urandom));
				for (int i = 0; i < 7; i++)
					send_byte(BYTE_W'($urandom));
			end
			END_BAD_EXT: begin
				set_config(1'b0, 3'd0);
				send_byte({1'($urandom), RSV_W'($urandom_range(1, 7)), OP_TEXT});
			end
			END_OP_CHANGED: begin
				send_byte({1'b0, 3'b000, OP_TEXT});
				send_byte(8'h01);
				send_byte(BYTE_W'($urandom));
				send_byte({1'b1, 3'b000, OP_BINARY});
			end
			END_UNKNOWN_OP: begin
				op = OP_TEXT;
				while (is_msg_opcode(op))
					op = OP_W'($urandom);
				send_byte({1'($urandom), 3'b000, op});
			end
			default: begin
				set_config(1'b1, 3'd0);
				send_byte({1'b1, 3'b000, OP_PING});
				send_byte({1'b0, 7'($urandom)});
			end
		endcase
		for (int i = 0; i < NOISE_BYTES; i++)
			send_byte(BYTE_W'($urandom));

		wait_drained();
		repeat (8) @(posedge clk);

		$display("tb: %0d results checked from %0d directed and %0d random bytes",
			results_checked, dir_count, bytes_sent - dir_count);
		$display("tb: %0d random messages over four register settings, closed by %s",
			msgs_sent, closing.name());
		if (bad_results == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[websocket_frame_rx_parser.f]
hw/rtl/wsfrx_pkg.sv
hw/rtl/wsfrx_byte_if.sv
hw/rtl/wsfrx_res_if.sv
hw/rtl/wsfrx_cfg_if.sv
hw/rtl/wsfrx_core.sv
hw/rtl/wsfrx_out_fifo.sv
hw/rtl/websocket_frame_rx_parser.sv
test/tb_websocket_frame_rx_parser.sv
